// ----- rtl/polyphonic_voice_allocator_top_defines.svh -----
// Assertion macros used by the voice allocator top level.
`ifndef POLYPHONIC_VOICE_ALLOCATOR_TOP_DEFINES_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define PVA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset.
`define PVA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pva_pkg.sv -----
// Shared constants, codes and control structs of the voice allocator.
`timescale 1ns / 1ps
package pva_pkg;

  localparam int POOL_A_VOICES_DEF = 6;
  localparam int POOL_B_VOICES_DEF = 6;
  localparam int POOL_C_VOICES_DEF = 18;

  localparam int KEY_W    = 7;
  localparam int VEL_W    = 7;
  localparam int TGT_W    = 3;
  localparam int VOICE_W  = 5;
  localparam int ST_W     = 3;
  localparam int ACT_W    = 8;
  localparam int MASK_A_W = 6;
  localparam int MASK_B_W = 6;
  localparam int MASK_C_W = 18;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 18;

  // result status codes
  localparam logic [ST_W-1:0] ST_IGNORED   = 3'd0;
  localparam logic [ST_W-1:0] ST_SET       = 3'd1;
  localparam logic [ST_W-1:0] ST_NO_FREE   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_MIDI      = 3'd4;

  // targets
  localparam logic [TGT_W-1:0] TGT_MIDI = 3'd0;
  localparam logic [TGT_W-1:0] TGT_A    = 3'd1;
  localparam logic [TGT_W-1:0] TGT_B    = 3'd2;
  localparam logic [TGT_W-1:0] TGT_C    = 3'd3;
  localparam logic [TGT_W-1:0] TGT_ALT  = 3'd4;

  // activity counters
  localparam logic [2:0] CTR_MIDI     = 3'd0;
  localparam logic [2:0] CTR_MIDI_ALT = 3'd1;
  localparam logic [2:0] CTR_A        = 3'd2;
  localparam logic [2:0] CTR_B        = 3'd3;
  localparam logic [2:0] CTR_C        = 3'd4;
  localparam int         NUM_CTR      = 5;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_MASK_A = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MASK_B = 2'd1;
  localparam logic [CFG_IW-1:0] REG_MASK_C = 2'd2;
  localparam logic [CFG_IW-1:0] REG_TWIN   = 2'd3;

  typedef struct packed {
    logic load;   // capture the input beat
    logic step;   // examine one voice
    logic apply;  // commit state, fill the result register
  } pva_cmd_t;

  typedef struct packed {
    logic direct; // no voice search needed
    logic hit;    // voice under the scan index matches
    logic last;   // scan index is on the pool's last voice
  } pva_sts_t;

endpackage

// ----- rtl/pva_if.sv -----
// Valid/ready stream interfaces for note events and results.
`timescale 1ns / 1ps
interface pva_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [pva_pkg::TGT_W-1:0]   target;
  logic [pva_pkg::VOICE_W-1:0] fixed_voice;
  logic [pva_pkg::KEY_W-1:0]   key;
  logic [pva_pkg::VEL_W-1:0]   velocity;
  logic                     alt_select;
  logic                     beat_event;

  modport source (output valid, action, target, fixed_voice, key, velocity, alt_select,
                  beat_event, input ready);
  modport sink   (input valid, action, target, fixed_voice, key, velocity, alt_select,
                  beat_event, output ready);
endinterface

interface pva_out_if;
  logic                        valid;
  logic                        ready;
  logic [pva_pkg::ST_W-1:0]    status;
  logic [pva_pkg::VOICE_W-1:0] voice;
  logic [pva_pkg::KEY_W-1:0]   out_key;
  logic [pva_pkg::VEL_W-1:0]   out_velocity;
  logic                        alt_port;
  logic                        twin_copy;
  logic [pva_pkg::ACT_W-1:0]   activity;

  modport source (output valid, status, voice, out_key, out_velocity, alt_port, twin_copy,
                  activity, input ready);
  modport sink   (input valid, status, voice, out_key, out_velocity, alt_port, twin_copy,
                  activity, output ready);
endinterface

// ----- rtl/pva_ctrl.sv -----
// Sequencer: capture, voice scan, commit and result handoff.
`timescale 1ns / 1ps
module pva_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pva_pkg::pva_sts_t sts,
  output pva_pkg::pva_cmd_t cmd
);
  import pva_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.direct || sts.hit || sts.last) begin
          state_nxt = S_APPLY;
        end
        cmd.step = !sts.direct;
      end
      S_APPLY: begin
        if (slot_free) begin
          cmd.apply     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/pva_dp.sv -----
// Datapath: voice pools, reserve masks, activity counters and result register.
`timescale 1ns / 1ps
module pva_dp #(
  parameter int POOL_A_VOICES = pva_pkg::POOL_A_VOICES_DEF,
  parameter int POOL_B_VOICES = pva_pkg::POOL_B_VOICES_DEF,
  parameter int POOL_C_VOICES = pva_pkg::POOL_C_VOICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pva_pkg::CFG_IW-1:0]  cfg_idx,
  input  logic [pva_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_action,
  input  logic [pva_pkg::TGT_W-1:0]   in_target,
  input  logic [pva_pkg::VOICE_W-1:0] in_fixed_voice,
  input  logic [pva_pkg::KEY_W-1:0]   in_key,
  input  logic [pva_pkg::VEL_W-1:0]   in_velocity,
  input  logic                        in_alt_select,
  input  logic                        in_beat_event,
  input  pva_pkg::pva_cmd_t           cmd,
  output pva_pkg::pva_sts_t           sts,
  output logic [pva_pkg::ST_W-1:0]    out_status,
  output logic [pva_pkg::VOICE_W-1:0] out_voice,
  output logic [pva_pkg::KEY_W-1:0]   out_key,
  output logic [pva_pkg::VEL_W-1:0]   out_velocity,
  output logic                        out_alt_port,
  output logic                        out_twin_copy,
  output logic [pva_pkg::ACT_W-1:0]   out_activity
);
  import pva_pkg::*;

  localparam int AWA = (POOL_A_VOICES > 1) ? $clog2(POOL_A_VOICES) : 1;
  localparam int AWB = (POOL_B_VOICES > 1) ? $clog2(POOL_B_VOICES) : 1;
  localparam int AWC = (POOL_C_VOICES > 1) ? $clog2(POOL_C_VOICES) : 1;
  localparam logic [5:0] NA = 6'(POOL_A_VOICES);
  localparam logic [5:0] NB = 6'(POOL_B_VOICES);
  localparam logic [5:0] NC = 6'(POOL_C_VOICES);

  // configuration
  logic [MASK_A_W-1:0] mask_a_r;
  logic [MASK_B_W-1:0] mask_b_r;
  logic [MASK_C_W-1:0] mask_c_r;
  logic                twin_r;

  // state
  logic [KEY_W-1:0] pool_a_r [POOL_A_VOICES];
  logic [KEY_W-1:0] pool_b_r [POOL_B_VOICES];
  logic [KEY_W-1:0] pool_c_r [POOL_C_VOICES];
  logic [ACT_W-1:0] act_r    [NUM_CTR];

  // captured beat
  logic               on_r, alt_r, ign_r, midi_r, direct_r, hit_r;
  logic [TGT_W-1:0]   tgt_r;
  logic [VOICE_W-1:0] fv_r, cnt_r, vidx_r;
  logic [KEY_W-1:0]   key_r;
  logic [VEL_W-1:0]   vel_r;

  // result register
  logic [ST_W-1:0]    st_r;
  logic [VOICE_W-1:0] voice_r;
  logic [KEY_W-1:0]   okey_r;
  logic [VEL_W-1:0]   ovel_r;
  logic               altp_r, twinc_r;
  logic [ACT_W-1:0]   actv_r;

  function automatic logic [5:0] pool_size(input logic [TGT_W-1:0] t);
    logic [5:0] n;
    n = 6'd1;
    case (t)
      TGT_A:   n = NA;
      TGT_B:   n = NB;
      TGT_C:   n = NC;
      default: n = 6'd1;
    endcase
    return n;
  endfunction

  // capture-time decode
  logic in_ign, in_midi, in_fixed;
  assign in_ign   = (in_action && in_key == '0) || (in_target > TGT_ALT);
  assign in_midi  = (in_target == TGT_MIDI) || (in_target == TGT_ALT);
  // beat note-on uses fixed_voice on every pool, beat note-off only on pool A
  assign in_fixed = in_beat_event && (in_action || in_target == TGT_A);

  // scan compare
  logic [5:0]       n_sel;
  logic [31:0]      res_vec;
  logic [KEY_W-1:0] note_sel;
  logic             hit_now;

  always_comb begin
    n_sel    = pool_size(tgt_r);
    res_vec  = '0;
    note_sel = '0;
    case (tgt_r)
      TGT_A: begin
        res_vec  = 32'(mask_a_r);
        note_sel = pool_a_r[cnt_r[AWA-1:0]];
      end
      TGT_B: begin
        res_vec  = 32'(mask_b_r);
        note_sel = pool_b_r[cnt_r[AWB-1:0]];
      end
      TGT_C: begin
        res_vec  = 32'(mask_c_r);
        note_sel = pool_c_r[cnt_r[AWC-1:0]];
      end
      default: ;
    endcase
    hit_now = on_r ? (!res_vec[cnt_r] && note_sel == '0)
                   : (key_r != '0 && note_sel == key_r);
  end

  assign sts.direct = direct_r;
  assign sts.hit    = hit_now;
  assign sts.last   = ({1'b0, cnt_r} == (n_sel - 6'd1));

  // commit logic
  logic [2:0]       ctr_idx;
  logic [ACT_W-1:0] cur, inc, dec1, dec2, act_new;
  logic [ST_W-1:0]  st_nxt;
  logic [VOICE_W-1:0] voice_nxt;
  logic             altp_nxt, twinc_nxt, act_we, pool_we;

  always_comb begin
    case (tgt_r)
      TGT_A:   ctr_idx = CTR_A;
      TGT_B:   ctr_idx = CTR_B;
      TGT_C:   ctr_idx = CTR_C;
      default: ctr_idx = alt_r ? CTR_MIDI_ALT : CTR_MIDI;
    endcase
    cur  = act_r[ctr_idx];
    inc  = cur + 8'd1;
    dec1 = (cur != '0)   ? cur - 8'd1 : '0;
    dec2 = (cur > 8'd1)  ? cur - 8'd2 : '0;

    st_nxt    = ST_IGNORED;
    voice_nxt = '0;
    altp_nxt  = 1'b0;
    twinc_nxt = 1'b0;
    act_new   = cur;
    act_we    = 1'b0;
    pool_we   = 1'b0;
    if (ign_r) begin
      act_new = '0;
    end else if (midi_r) begin
      st_nxt    = ST_MIDI;
      voice_nxt = fv_r;
      altp_nxt  = (tgt_r == TGT_ALT) || alt_r;
      twinc_nxt = twin_r;
      act_new   = on_r ? inc : (twin_r ? dec2 : dec1);
      act_we    = 1'b1;
    end else begin
      act_we    = 1'b1;
      pool_we   = hit_r;
      voice_nxt = hit_r ? vidx_r : '0;
      if (on_r) begin
        act_new = inc;
        st_nxt  = hit_r ? ST_SET : ST_NO_FREE;
      end else begin
        act_new = hit_r ? dec1 : cur;
        st_nxt  = hit_r ? ST_SET : ST_NOT_FOUND;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_a_r <= '0;
      mask_b_r <= '0;
      mask_c_r <= '0;
      twin_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MASK_A: mask_a_r <= cfg_data[MASK_A_W-1:0];
        REG_MASK_B: mask_b_r <= cfg_data[MASK_B_W-1:0];
        REG_MASK_C: mask_c_r <= cfg_data[MASK_C_W-1:0];
        REG_TWIN:   twin_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // capture and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      on_r     <= in_action;
      tgt_r    <= in_target;
      fv_r     <= in_fixed_voice;
      key_r    <= in_key;
      vel_r    <= in_velocity;
      alt_r    <= in_alt_select;
      ign_r    <= in_ign;
      midi_r   <= in_midi;
      direct_r <= in_ign || in_midi || in_fixed;
      hit_r    <= in_fixed && ({1'b0, in_fixed_voice} < pool_size(in_target));
      vidx_r   <= in_fixed_voice;
      cnt_r    <= '0;
    end else if (cmd.step) begin
      if (hit_now) begin
        hit_r  <= 1'b1;
        vidx_r <= cnt_r;
      end else begin
        cnt_r  <= cnt_r + 5'd1;
      end
    end
  end

  // pools and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_A_VOICES; i++) pool_a_r[i] <= '0;
      for (int i = 0; i < POOL_B_VOICES; i++) pool_b_r[i] <= '0;
      for (int i = 0; i < POOL_C_VOICES; i++) pool_c_r[i] <= '0;
      for (int i = 0; i < NUM_CTR; i++)       act_r[i]    <= '0;
    end else if (cmd.apply) begin
      if (act_we) act_r[ctr_idx] <= act_new;
      if (pool_we) begin
        case (tgt_r)
          TGT_A:   pool_a_r[vidx_r[AWA-1:0]] <= on_r ? key_r : '0;
          TGT_B:   pool_b_r[vidx_r[AWB-1:0]] <= on_r ? key_r : '0;
          TGT_C:   pool_c_r[vidx_r[AWC-1:0]] <= on_r ? key_r : '0;
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      st_r    <= st_nxt;
      voice_r <= voice_nxt;
      okey_r  <= ign_r ? '0 : key_r;
      ovel_r  <= ign_r ? '0 : vel_r;
      altp_r  <= altp_nxt;
      twinc_r <= twinc_nxt;
      actv_r  <= act_new;
    end
  end

  assign out_status    = st_r;
  assign out_voice     = voice_r;
  assign out_key       = okey_r;
  assign out_velocity  = ovel_r;
  assign out_alt_port  = altp_r;
  assign out_twin_copy = twinc_r;
  assign out_activity  = actv_r;

endmodule

// ----- rtl/polyphonic_voice_allocator_top.sv -----
// Top level of the polyphonic voice allocator.
`timescale 1ns / 1ps
// Usage:
//   in_ch  - note events (action, target, fixed_voice, key, velocity,
//            alt_select, beat_event); a beat moves on valid && ready.
//   out_ch - one result beat per event (status, voice, out_key,
//            out_velocity, alt_port, twin_copy, activity).
//   cfg_*  - write-only registers: 0/1/2 reserve masks of pools A/B/C,
//            3 twin link. Write only while no event is in flight.
// One event at a time. MIDI, ignored and beat note-on events (and beat
// note-offs on pool A) skip the pool search. A pool search visits one
// voice per cycle and visits at most the pool size (18 voices for pool C).
// in_ch.ready returns in the cycle the result turns valid, so the next
// event is accepted only after the previous one has committed.
// Reset clears all pools (every voice free), counters, configuration registers and the sequencer state at once.
// A stalled result waits in the output register; the block still takes the
// next event and searches, and holds its commit until the register frees.
module polyphonic_voice_allocator_top #(
  parameter int POOL_A_VOICES = pva_pkg::POOL_A_VOICES_DEF,
  parameter int POOL_B_VOICES = pva_pkg::POOL_B_VOICES_DEF,
  parameter int POOL_C_VOICES = pva_pkg::POOL_C_VOICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pva_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [pva_pkg::CFG_DW-1:0] cfg_data,
  pva_in_if.sink                     in_ch,
  pva_out_if.source                  out_ch
);
  import pva_pkg::*;
  `include "polyphonic_voice_allocator_top_defines.svh"

  pva_cmd_t cmd;
  pva_sts_t sts;

  pva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pva_dp #(
    .POOL_A_VOICES (POOL_A_VOICES),
    .POOL_B_VOICES (POOL_B_VOICES),
    .POOL_C_VOICES (POOL_C_VOICES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_action      (in_ch.action),
    .in_target      (in_ch.target),
    .in_fixed_voice (in_ch.fixed_voice),
    .in_key         (in_ch.key),
    .in_velocity    (in_ch.velocity),
    .in_alt_select  (in_ch.alt_select),
    .in_beat_event  (in_ch.beat_event),
    .cmd            (cmd),
    .sts            (sts),
    .out_status     (out_ch.status),
    .out_voice      (out_ch.voice),
    .out_key        (out_ch.out_key),
    .out_velocity   (out_ch.out_velocity),
    .out_alt_port   (out_ch.alt_port),
    .out_twin_copy  (out_ch.twin_copy),
    .out_activity   (out_ch.activity)
  );

  `PVA_ASSERT(a_no_overwrite, cmd.apply, !out_ch.valid || out_ch.ready, "result overwritten")
  `PVA_ASSERT(a_cmd_excl, cmd.load, !cmd.apply && !cmd.step, "load overlaps commit or scan")
  `PVA_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
                  "accepted while busy")
  `PVA_ASSERT(a_ignored_clean, out_ch.valid && out_ch.status == ST_IGNORED,
              out_ch.voice == '0 && out_ch.activity == '0 && out_ch.out_key == '0,
              "ignored result not cleared")

endmodule

// ----- verif/tb_polyphonic_voice_allocator_top.sv -----
// Self-checking testbench for the polyphonic voice allocator top level.
`timescale 1ns / 1ps
module tb_polyphonic_voice_allocator_top;
  import pva_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic               action;
    logic [TGT_W-1:0]   target;
    logic [VOICE_W-1:0] fixed_voice;
    logic [KEY_W-1:0]   key;
    logic [VEL_W-1:0]   velocity;
    logic               alt_select;
    logic               beat_event;
  } note_event_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [VOICE_W-1:0] voice;
    logic [KEY_W-1:0]   out_key;
    logic [VEL_W-1:0]   out_velocity;
    logic               alt_port;
    logic               twin_copy;
    logic [ACT_W-1:0]   activity;
  } voice_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_IW-1:0]  cfg_idx;
  logic [CFG_DW-1:0]  cfg_data;

  pva_in_if  in_ch();
  pva_out_if out_ch();

  polyphonic_voice_allocator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // shadow state of the allocator: pools A, B, C as rows 0, 1, 2
  logic [KEY_W-1:0]    pool_notes [0:2][0:17];
  logic [MASK_C_W-1:0] pool_mask  [0:2];
  logic                twin_link;
  logic [ACT_W-1:0]    activity_cnt [0:NUM_CTR-1];

  voice_result_t results_due [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 12;
  int recv_idle_pct = 86;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pool_size(int p);
    case (p)
      0: return POOL_A_VOICES_DEF;
      1: return POOL_B_VOICES_DEF;
      default: return POOL_C_VOICES_DEF;
    endcase
  endfunction

  function automatic void lower_count(int c);
    if (activity_cnt[c] != '0)
      activity_cnt[c] = activity_cnt[c] - ACT_W'(1);
  endfunction

  // expected result of one event; updates the shadow state
  function automatic voice_result_t compute_voice_result(note_event_t ev);
    voice_result_t r;
    int p, n, v, c, i;
    r = '0;
    if ((ev.action && ev.key == '0) || ev.target > TGT_ALT)
      return r;
    r.out_key      = ev.key;
    r.out_velocity = ev.velocity;
    if (ev.target == TGT_MIDI || ev.target == TGT_ALT) begin
      c = ev.alt_select ? int'(CTR_MIDI_ALT) : int'(CTR_MIDI);
      if (ev.action) begin
        activity_cnt[c] = activity_cnt[c] + ACT_W'(1);
      end else begin
        lower_count(c);
        if (twin_link)
          lower_count(c);
      end
      r.status    = ST_MIDI;
      r.voice     = ev.fixed_voice;
      r.alt_port  = (ev.target == TGT_ALT) || ev.alt_select;
      r.twin_copy = twin_link;
      r.activity  = activity_cnt[c];
      return r;
    end
    p = int'(ev.target) - int'(TGT_A);
    n = pool_size(p);
    c = int'(CTR_A) + p;
    v = -1;
    if (ev.action) begin
      if (ev.beat_event) begin
        if (int'(ev.fixed_voice) < n)
          v = int'(ev.fixed_voice);
      end else begin
        for (i = 0; i < n && v < 0; i++)
          if (!pool_mask[p][i] && pool_notes[p][i] == '0)
            v = i;
      end
      if (v >= 0)
        pool_notes[p][v] = ev.key;
      activity_cnt[c] = activity_cnt[c] + ACT_W'(1);
      r.status = (v >= 0) ? ST_SET : ST_NO_FREE;
    end else begin
      // only pool A frees a fixed voice on a beat note-off
      if (ev.beat_event && ev.target == TGT_A) begin
        if (int'(ev.fixed_voice) < n)
          v = int'(ev.fixed_voice);
      end else if (ev.key != '0) begin
        for (i = 0; i < n && v < 0; i++)
          if (pool_notes[p][i] == ev.key)
            v = i;
      end
      if (v >= 0) begin
        pool_notes[p][v] = '0;
        lower_count(c);
        r.status = ST_SET;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    r.voice    = (v >= 0) ? v[VOICE_W-1:0] : '0;
    r.activity = activity_cnt[c];
    return r;
  endfunction

  function automatic note_event_t note_event(logic action, logic [TGT_W-1:0] target,
                                             int fv, int key, int vel, logic alt,
                                             logic beat);
    note_event_t ev;
    ev.action      = action;
    ev.target      = target;
    ev.fixed_voice = fv[VOICE_W-1:0];
    ev.key         = key[KEY_W-1:0];
    ev.velocity    = vel[VEL_W-1:0];
    ev.alt_select  = alt;
    ev.beat_event  = beat;
    return ev;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_event(note_event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= ev.action;
    in_ch.target      <= ev.target;
    in_ch.fixed_voice <= ev.fixed_voice;
    in_ch.key         <= ev.key;
    in_ch.velocity    <= ev.velocity;
    in_ch.alt_select  <= ev.alt_select;
    in_ch.beat_event  <= ev.beat_event;
    do @(posedge clk); while (!in_ch.ready);
    results_due.push_back(compute_voice_result(ev));
    @(negedge clk);
  endtask

  // sender goes quiet until every result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CFG_DW-1:0];
    case (idx)
      REG_MASK_A: pool_mask[0] = MASK_C_W'(value[MASK_A_W-1:0]);
      REG_MASK_B: pool_mask[1] = MASK_C_W'(value[MASK_B_W-1:0]);
      REG_MASK_C: pool_mask[2] = value[MASK_C_W-1:0];
      REG_TWIN:   twin_link    = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(int mask_a, int mask_b, int mask_c, int twin);
    drain_results();
    repeat (4) @(negedge clk);
    write_reg(REG_MASK_A, mask_a);
    write_reg(REG_MASK_B, mask_b);
    write_reg(REG_MASK_C, mask_c);
    write_reg(REG_TWIN, twin);
  endtask

  function automatic int random_voice_field();
    return ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(17);
  endfunction

  // mostly pool note-on/off pairs on held keys, plus MIDI and noise
  function automatic note_event_t random_event();
    note_event_t ev;
    int pick, p, idx, tries;
    ev = note_event(1'($urandom_range(1)), TGT_MIDI, random_voice_field(),
                    $urandom_range(1, 127), $urandom_range(127),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
    pick = $urandom_range(99);
    if (pick < 25) begin
      ev.target = $urandom_range(1) ? TGT_ALT : TGT_MIDI;
      if (!ev.action && $urandom_range(9) == 0)
        ev.key = '0;
    end else if (pick < 60) begin
      ev.action     = 1'b1;
      ev.target     = TGT_A + TGT_W'($urandom_range(2));
      ev.beat_event = ($urandom_range(4) == 0);
      if ($urandom_range(3) == 0)
        ev.key = KEY_W'($urandom_range(1, 8));
    end else if (pick < 90) begin
      p             = $urandom_range(2);
      ev.action     = 1'b0;
      ev.target     = TGT_A + TGT_W'(p);
      ev.beat_event = ($urandom_range(4) == 0);
      for (tries = 0; tries < 4; tries++) begin
        idx = $urandom_range(pool_size(p) - 1);
        if (pool_notes[p][idx] != '0) begin
          ev.key = pool_notes[p][idx];
          if (ev.beat_event && $urandom_range(3) != 0)
            ev.fixed_voice = VOICE_W'(idx);
          break;
        end
      end
    end else begin
      ev.target = ($urandom_range(3) == 0) ? TGT_W'($urandom_range(7))
                                           : TGT_W'($urandom_range(5, 7));
      if ($urandom_range(2) == 0)
        ev.key = '0;
    end
    return ev;
  endfunction

  task automatic test_midi_events();
    send_event(note_event(1'b0, TGT_MIDI, 0, 0, 0, 1'b0, 1'b0));    // counter holds at zero
    send_event(note_event(1'b1, TGT_ALT, 17, 127, 127, 1'b0, 1'b1));
    send_event(note_event(1'b1, TGT_MIDI, 9, 1, 0, 1'b1, 1'b0));
    send_event(note_event(1'b1, TGT_MIDI, 3, 1, 5, 1'b1, 1'b0));
    send_event(note_event(1'b1, TGT_A, 2, 0, 64, 1'b0, 1'b0));      // note-on key 0
    send_event(note_event(1'b0, 3'd7, 31, 127, 127, 1'b1, 1'b1));   // bad target
    send_event(note_event(1'b1, 3'd5, 4, 60, 1, 1'b0, 1'b0));
    apply_settings(0, 0, 0, 1);
    send_event(note_event(1'b0, TGT_MIDI, 1, 60, 10, 1'b1, 1'b0));  // twin: down by two
    send_event(note_event(1'b0, TGT_ALT, 16, 61, 20, 1'b0, 1'b0));
  endtask

  task automatic test_pool_events();
    int k;
    apply_settings(6'b000011, 6'b100000, 18'h20001, 0);
    for (k = 10; k < 15; k++)
      send_event(note_event(1'b1, TGT_A, 0, k, k, 1'b0, 1'b0));     // last one finds no voice
    send_event(note_event(1'b1, TGT_A, 0, 127, 3, 1'b0, 1'b1));     // reserved voice
    send_event(note_event(1'b1, TGT_A, 3, 20, 4, 1'b0, 1'b1));      // busy voice
    send_event(note_event(1'b1, TGT_A, 17, 21, 5, 1'b0, 1'b1));     // outside the pool
    send_event(note_event(1'b0, TGT_A, 0, 11, 6, 1'b0, 1'b0));      // key was overwritten
    send_event(note_event(1'b0, TGT_A, 0, 10, 7, 1'b0, 1'b0));
    send_event(note_event(1'b0, TGT_A, 0, 0, 8, 1'b0, 1'b0));
    send_event(note_event(1'b0, TGT_A, 0, 99, 9, 1'b0, 1'b1));      // frees fixed voice
    send_event(note_event(1'b0, TGT_A, 17, 20, 9, 1'b0, 1'b1));
    send_event(note_event(1'b0, TGT_B, 3, 5, 1, 1'b0, 1'b1));
    send_event(note_event(1'b1, TGT_B, 3, 5, 1, 1'b0, 1'b0));
    send_event(note_event(1'b0, TGT_B, 3, 5, 1, 1'b0, 1'b1));       // searched by key
    send_event(note_event(1'b1, TGT_C, 0, 99, 1, 1'b0, 1'b0));
    send_event(note_event(1'b1, TGT_C, 17, 98, 2, 1'b0, 1'b1));
    send_event(note_event(1'b0, TGT_C, 0, 98, 3, 1'b0, 1'b0));
  endtask

  // enough note-ons on one MIDI counter to wrap it
  task automatic test_counter_wrap();
    int k;
    for (k = 0; k < 280; k++)
      send_event(note_event(1'b1, $urandom_range(1) ? TGT_ALT : TGT_MIDI,
                            $urandom_range(17), $urandom_range(1, 127),
                            $urandom_range(127), 1'b1, 1'($urandom_range(1))));
  endtask

  task automatic test_random_traffic(int per_phase);
    int k;
    apply_settings($urandom_range(63), $urandom_range(63), $urandom_range(18'h3FFFF),
                   $urandom_range(1));
    send_idle_pct = 12;
    recv_idle_pct = 86;
    for (k = 0; k < per_phase; k++)
      send_event(random_event());
    apply_settings(6'h3F, 6'h3F, 18'h3FFFF, 1);
    send_idle_pct = 86;
    recv_idle_pct = 12;
    for (k = 0; k < per_phase; k++)
      send_event(random_event());
    apply_settings(0, 0, 0, 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (k = 0; k < per_phase; k++)
      send_event(random_event());
  endtask

  initial begin
    int p, i;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = 1'b0;
    in_ch.target       = '0;
    in_ch.fixed_voice  = '0;
    in_ch.key          = '0;
    in_ch.velocity     = '0;
    in_ch.alt_select   = 1'b0;
    in_ch.beat_event   = 1'b0;
    for (p = 0; p < 3; p++) begin
      pool_mask[p] = '0;
      for (i = 0; i < 18; i++)
        pool_notes[p][i] = '0;
    end
    for (i = 0; i < NUM_CTR; i++)
      activity_cnt[i] = '0;
    twin_link = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_midi_events();
    test_pool_events();
    test_counter_wrap();
    test_random_traffic(320);

    drain_results();
    repeat (30) @(negedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    voice_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result beat with none expected, actual status %0d voice %0d",
                 $time, out_ch.status, out_ch.voice);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        check_field("status", int'(want.status), int'(out_ch.status));
        check_field("voice", int'(want.voice), int'(out_ch.voice));
        check_field("out_key", int'(want.out_key), int'(out_ch.out_key));
        check_field("out_velocity", int'(want.out_velocity), int'(out_ch.out_velocity));
        check_field("alt_port", int'(want.alt_port), int'(out_ch.alt_port));
        check_field("twin_copy", int'(want.twin_copy), int'(out_ch.twin_copy));
        check_field("activity", int'(want.activity), int'(out_ch.activity));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule
